// File: design/fucd_pkg.sv
// Package for the fuzzy union centroid defuzzifier.
// Holds widths, register indexes, state codes and shared structs; no dependencies.
package fucd_pkg;

    localparam int MaxPoints   = 8;
    localparam int MaxSamples  = 1024;
    localparam int PosW        = 16;
    localparam int DegW        = 9;
    localparam int IdxW        = 3;
    localparam int CntW        = 11;
    localparam int NptW        = 4;
    localparam int XW          = 27;
    localparam int NumW        = 25;
    localparam int AreaW       = 24;
    localparam int MomW        = 48;
    localparam int DsrW        = 25;
    localparam int ItW         = 6;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 16;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_START = 3'd0,
        CFG_STEP  = 3'd1,
        CFG_COUNT = 3'd2,
        CFG_CNT_A = 3'd3,
        CFG_CNT_B = 3'd4,
        CFG_MODE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK1,
        ST_LOOK2,
        ST_EVAL,
        ST_DIV,
        ST_COMB,
        ST_MUL,
        ST_ADD,
        ST_FINAL,
        ST_FDIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              direct;
        logic [DegW-1:0]   value;
        logic [NumW-1:0]   num;
        logic [PosW-1:0]   dx;
    } t_seg;

    typedef struct packed {
        logic              start;
        logic [DsrW-1:0]   rem;
        logic [MomW-1:0]   dvd;
        logic [DsrW-1:0]   dsr;
        logic [ItW-1:0]    iters;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [MomW-1:0]   quo;
    } t_div_rsp;

endpackage

// File: design/fucd_in_if.sv
// Input channel of the defuzzifier: breakpoint loads and run requests.
// Depends on fucd_pkg for field widths.
interface fucd_in_if;
    import fucd_pkg::*;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic                set_select;
    logic [IdxW-1:0]     point_index;
    logic [PosW-1:0]     point_position;
    logic [DegW-1:0]     point_degree;

    modport source (output valid, req_type, set_select, point_index, point_position,
                    point_degree, input ready);
    modport sink   (input valid, req_type, set_select, point_index, point_position,
                    point_degree, output ready);
endinterface

// File: design/fucd_out_if.sv
// Output channel of the defuzzifier: one centroid beat per run.
// Depends on fucd_pkg for field widths.
interface fucd_out_if;
    import fucd_pkg::*;
    logic                valid;
    logic                ready;
    logic [PosW-1:0]     centroid;
    logic                empty_area;

    modport source (output valid, centroid, empty_area, input ready);
    modport sink   (input valid, centroid, empty_area, output ready);
endinterface

// File: design/fucd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fucd_pkg for the request and response structs.
module fucd_div
    import fucd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic [DsrW-1:0] r_rem, n_rem;
    logic [MomW-1:0] r_dvd;
    logic [DsrW-1:0] r_dsr;
    logic [MomW-1:0] r_quo;
    logic [ItW-1:0]  r_cnt;
    logic            r_busy;
    logic            r_done;
    logic [DsrW:0]   w_sh;
    logic            w_ge;

    assign w_sh = {r_rem, r_dvd[MomW-1]};
    assign w_ge = w_sh >= {1'b0, r_dsr};

    always_comb begin
        if (w_ge) begin
            n_rem = DsrW'(w_sh - {1'b0, r_dsr});
        end else begin
            n_rem = w_sh[DsrW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ItW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_dvd <= i_req.dvd;
            r_dsr <= i_req.dsr;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[MomW-2:0], 1'b0};
            r_quo <= {r_quo[MomW-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: design/fucd_store.sv
// Breakpoint store and two-stage segment lookup for both membership functions.
// Depends on fucd_pkg; result feeds the shared divider in the top level.
module fucd_store
    import fucd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_wr_set,
    input  logic [IdxW-1:0]   i_wr_idx,
    input  logic [PosW-1:0]   i_wr_pos,
    input  logic [DegW-1:0]   i_wr_deg,
    input  logic              i_set,
    input  logic [NptW-1:0]   i_npt,
    input  logic [XW-1:0]     i_x,
    output t_seg              o_seg
);

    logic [PosW-1:0] r_pos [2][MaxPoints];
    logic [DegW-1:0] r_deg [2][MaxPoints];

    logic [MaxPoints-1:0] w_ge, w_le;
    logic                 w_hit;
    logic [IdxW-1:0]      w_hit_i;
    logic [IdxW-1:0]      w_last;

    logic                 r1_direct;
    logic [DegW-1:0]      r1_value;
    logic [IdxW-1:0]      r1_i;
    logic                 r1_set;
    logic [PosW-1:0]      r1_x;

    logic [IdxW-1:0]      w_j;
    logic [PosW-1:0]      w_p0, w_p1;
    logic [DegW-1:0]      w_u0, w_u1;
    logic [PosW-1:0]      w_dx;
    t_seg                 n_seg, r_seg;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos[i_wr_set][i_wr_idx] <= i_wr_pos;
            r_deg[i_wr_set][i_wr_idx] <= i_wr_deg;
        end
    end

    assign w_last = IdxW'(i_npt - 1'b1);

    always_comb begin
        w_hit   = 1'b0;
        w_hit_i = '0;
        for (int i = 0; i < MaxPoints; i++) begin
            w_ge[i] = i_x >= XW'(r_pos[i_set][i]);
            w_le[i] = i_x <= XW'(r_pos[i_set][i]);
        end
        for (int i = MaxPoints - 2; i >= 0; i--) begin
            if ((i + 1 < int'(i_npt)) && w_ge[i] && w_le[i+1]) begin
                w_hit   = 1'b1;
                w_hit_i = IdxW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_set <= i_set;
        r1_x   <= i_x[PosW-1:0];
        r1_i   <= w_hit_i;
        if (!w_ge[0]) begin
            r1_direct <= 1'b1;
            r1_value  <= r_deg[i_set][0];
        end else if (i_x > XW'(r_pos[i_set][w_last]) || !w_hit) begin
            r1_direct <= 1'b1;
            r1_value  <= r_deg[i_set][w_last];
        end else begin
            r1_direct <= 1'b0;
            r1_value  <= '0;
        end
    end

    assign w_j  = r1_i + 1'b1;
    assign w_p0 = r_pos[r1_set][r1_i];
    assign w_p1 = r_pos[r1_set][w_j];
    assign w_u0 = r_deg[r1_set][r1_i];
    assign w_u1 = r_deg[r1_set][w_j];
    assign w_dx = w_p1 - w_p0;

    always_comb begin
        n_seg.dx = w_dx;
        if (r1_direct) begin
            n_seg.direct = 1'b1;
            n_seg.value  = r1_value;
            n_seg.num    = '0;
        end else if (w_dx == '0 || w_u0 == w_u1) begin
            n_seg.direct = 1'b1;
            n_seg.value  = w_u0;
            n_seg.num    = '0;
        end else if (w_u0 < w_u1) begin
            n_seg.direct = 1'b0;
            n_seg.value  = w_u0;
            n_seg.num    = NumW'((r1_x - w_p0) * (w_u1 - w_u0));
        end else begin
            n_seg.direct = 1'b0;
            n_seg.value  = w_u1;
            n_seg.num    = NumW'((w_p1 - r1_x) * (w_u0 - w_u1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;

endmodule

// File: design/fuzzy_union_centroid_defuzzifier.sv
// Fuzzy union/intersection centroid defuzzifier, top level.
// Steps: a load writes one breakpoint. A run does, for each sample, two lookups through the
// store, each followed by a divide on a sloped segment, then combines the two degrees and,
// from the second sample on, accumulates; after the last sample, a final divide if area is nonzero.
// Throughput: one item at a time; not ready during a run; a stalled result holds the sequencer.
// Reset is synchronous, active low: control and config registers return to defaults, breakpoints are not cleared.
module fuzzy_union_centroid_defuzzifier
    import fucd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fucd_in_if.sink              i_in,
    fucd_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgDataW-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [PosW-1:0] r_start, r_step;
    logic [CntW-1:0] r_count;
    logic [NptW-1:0] r_cnt_a, r_cnt_b;
    logic            r_mode;

    logic [CntW-1:0] w_cnt;
    logic [NptW-1:0] w_na, w_nb, w_npt;
    logic [CntW-1:0] r_k;
    logic [XW-1:0]   r_x, r_xprev;
    logic            r_set;
    logic [DegW-1:0] r_da, r_db, r_prev, w_d, w_deg;
    logic [DegW:0]   r_s;
    logic [XW+11:0]  r_prod;
    logic [AreaW-1:0] r_area;
    logic [MomW-1:0]  r_mom;
    logic [PosW-1:0]  r_cen, r_ocen;
    logic             r_empty, r_oempty, r_ovalid;
    logic             w_in_acc, w_last, w_out_free;

    t_seg     w_seg;
    t_div_req w_req;
    t_div_rsp w_rsp;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    always_comb begin
        if (r_count < CntW'(2)) begin
            w_cnt = CntW'(2);
        end else if (r_count > CntW'(MaxSamples)) begin
            w_cnt = CntW'(MaxSamples);
        end else begin
            w_cnt = r_count;
        end
        w_na = (r_cnt_a == '0) ? NptW'(1) : (r_cnt_a > NptW'(MaxPoints)) ? NptW'(MaxPoints) : r_cnt_a;
        w_nb = (r_cnt_b == '0) ? NptW'(1) : (r_cnt_b > NptW'(MaxPoints)) ? NptW'(MaxPoints) : r_cnt_b;
        w_npt = r_set ? w_nb : w_na;
    end

    assign w_last = r_k == CntW'(w_cnt - 1'b1);
    assign w_d    = r_mode ? ((r_da > r_db) ? r_da : r_db) : ((r_da < r_db) ? r_da : r_db);
    assign w_deg  = (r_state == ST_DIV) ? DegW'(w_seg.value + w_rsp.quo[DegW-1:0]) : w_seg.value;

    fucd_store u_store (
        .i_clk    (i_clk),
        .i_we     (w_in_acc && !i_in.req_type),
        .i_wr_set (i_in.set_select),
        .i_wr_idx (i_in.point_index),
        .i_wr_pos (i_in.point_position),
        .i_wr_deg (i_in.point_degree),
        .i_set    (r_set),
        .i_npt    (w_npt),
        .i_x      (r_x),
        .o_seg    (w_seg)
    );

    fucd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_req = '0;
        if (r_state == ST_EVAL && !w_seg.direct) begin
            w_req.start = 1'b1;
            w_req.rem   = DsrW'(w_seg.num[NumW-1:DegW]);
            w_req.dvd   = {w_seg.num[DegW-1:0], (MomW-DegW)'(0)};
            w_req.dsr   = DsrW'(w_seg.dx);
            w_req.iters = ItW'(DegW);
        end else if (r_state == ST_FINAL && r_area != '0) begin
            w_req.start = 1'b1;
            w_req.rem   = '0;
            w_req.dvd   = r_mom + MomW'(r_area);
            w_req.dsr   = {r_area, 1'b0};
            w_req.iters = ItW'(MomW);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && i_in.req_type) n_state = ST_LOOK1;
            ST_LOOK1: n_state = ST_LOOK2;
            ST_LOOK2: n_state = ST_EVAL;
            ST_EVAL: begin
                if (!w_seg.direct) n_state = ST_DIV;
                else if (r_set)    n_state = ST_COMB;
                else               n_state = ST_LOOK1;
            end
            ST_DIV: begin
                if (w_rsp.done) n_state = r_set ? ST_COMB : ST_LOOK1;
            end
            ST_COMB: begin
                if (r_k != '0) n_state = ST_MUL;
                else           n_state = ST_LOOK1;
            end
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = w_last ? ST_FINAL : ST_LOOK1;
            ST_FINAL: n_state = (r_area == '0) ? ST_OUT : ST_FDIV;
            ST_FDIV:  if (w_rsp.done) n_state = ST_OUT;
            ST_OUT:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= '0;
            r_step   <= PosW'(16);
            r_count  <= CntW'(101);
            r_cnt_a  <= NptW'(3);
            r_cnt_b  <= NptW'(3);
            r_mode   <= 1'b1;
            r_ovalid <= 1'b0;
            r_area   <= '0;
            r_mom    <= '0;
            r_prev   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START: r_start <= i_cfg_data;
                    CFG_STEP:  r_step  <= i_cfg_data;
                    CFG_COUNT: r_count <= i_cfg_data[CntW-1:0];
                    CFG_CNT_A: r_cnt_a <= i_cfg_data[NptW-1:0];
                    CFG_CNT_B: r_cnt_b <= i_cfg_data[NptW-1:0];
                    CFG_MODE:  r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == ST_IDLE && w_in_acc && i_in.req_type) begin
                r_area <= '0;
                r_mom  <= '0;
            end
            if (r_state == ST_COMB && r_k == '0) r_prev <= w_d;
            if (r_state == ST_ADD) begin
                r_area <= r_area + AreaW'(r_s);
                r_mom  <= r_mom + MomW'(r_prod);
                r_prev <= w_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_k     <= '0;
                r_x     <= XW'(r_start);
                r_xprev <= XW'(r_start);
                r_set   <= 1'b0;
            end
            ST_EVAL: begin
                if (w_seg.direct) begin
                    if (r_set) r_db <= w_deg;
                    else       r_da <= w_deg;
                    r_set <= 1'b1;
                end
            end
            ST_DIV: begin
                if (w_rsp.done) begin
                    if (r_set) r_db <= w_deg;
                    else       r_da <= w_deg;
                    r_set <= 1'b1;
                end
            end
            ST_COMB: begin
                r_s <= (DegW+1)'(r_prev) + (DegW+1)'(w_d);
                if (r_k == '0) begin
                    r_k     <= r_k + 1'b1;
                    r_set   <= 1'b0;
                    r_xprev <= r_x;
                    r_x     <= r_x + XW'(r_step);
                end
            end
            ST_MUL: begin
                r_prod <= r_s * ({r_xprev, 1'b0} + (XW+1)'(r_step));
            end
            ST_ADD: begin
                r_k     <= r_k + 1'b1;
                r_set   <= 1'b0;
                r_xprev <= r_x;
                r_x     <= r_x + XW'(r_step);
            end
            ST_FINAL: begin
                r_cen   <= '0;
                r_empty <= (r_area == '0);
            end
            ST_FDIV: begin
                if (w_rsp.done) begin
                    r_cen <= (w_rsp.quo > MomW'(16'hFFFF)) ? 16'hFFFF : w_rsp.quo[PosW-1:0];
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_ocen   <= r_cen;
                    r_oempty <= r_empty;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.centroid   = r_ocen;
    assign o_out.empty_area = r_oempty;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_area |-> o_out.centroid == '0)
        else $error("empty area with nonzero centroid");

    a_div_idle_at_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> !w_rsp.busy)
        else $error("divider busy while result is posted");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("divider restarted while busy");

endmodule

// File: tb/fuzzy_union_centroid_defuzzifier_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_union_centroid_defuzzifier: loads breakpoints, runs
// centroid passes under several register settings and checks each beat against a local
// predictor. Depends on fucd_pkg, fucd_in_if and fucd_out_if.
module fuzzy_union_centroid_defuzzifier_tb;
    import fucd_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgUnused = 3'd6;
    localparam bit ReqLoad = 1'b0;
    localparam bit ReqRun  = 1'b1;
    localparam bit SetA    = 1'b0;
    localparam bit SetB    = 1'b1;

    typedef struct {
        bit              req;
        bit              sel;
        bit [IdxW-1:0]   idx;
        bit [PosW-1:0]   pos;
        bit [DegW-1:0]   deg;
    } t_fuzzy_req;

    typedef struct {
        bit [PosW-1:0]   centroid;
        bit              empty;
    } t_centroid;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    fucd_in_if  in_if();
    fucd_out_if out_if();

    fuzzy_union_centroid_defuzzifier i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_out      (out_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_fuzzy_req    pending_q[$];
    t_centroid     centroid_q[$];
    longint unsigned bp_pos[2*MaxPoints];
    int unsigned     bp_deg[2*MaxPoints];
    int unsigned start_pos = 0, step = 16, samples = 101, cnt_a = 3, cnt_b = 3, mode = 1;
    int errors = 0, loads = 0, runs = 0, checked = 0;
    int in_gap = 0, out_stall = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(20ns * 2_000_000);
        $display("tb: failure");
        $finish;
    end

    task automatic report(string what, int unsigned got, int unsigned want);
        errors++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int unsigned degree_at(int sel, int unsigned n, longint unsigned x);
        int b;
        longint unsigned dx;
        b = sel * MaxPoints;
        if (x < bp_pos[b]) return bp_deg[b];
        if (x > bp_pos[b+n-1]) return bp_deg[b+n-1];
        for (int i = 0; i + 1 < n; i++) begin
            if (x >= bp_pos[b+i] && x <= bp_pos[b+i+1]) begin
                dx = bp_pos[b+i+1] - bp_pos[b+i];
                if (dx == 0) return bp_deg[b+i];
                if (bp_deg[b+i] < bp_deg[b+i+1])
                    return bp_deg[b+i] + int'((x - bp_pos[b+i]) *
                        longint'(bp_deg[b+i+1] - bp_deg[b+i]) / dx);
                if (bp_deg[b+i] > bp_deg[b+i+1])
                    return bp_deg[b+i+1] + int'((bp_pos[b+i+1] - x) *
                        longint'(bp_deg[b+i] - bp_deg[b+i+1]) / dx);
                return bp_deg[b+i];
            end
        end
        return bp_deg[b+n-1];
    endfunction

    function automatic int unsigned clamp_pts(int unsigned n);
        return n < 1 ? 1 : (n > MaxPoints ? MaxPoints : n);
    endfunction

    function automatic int unsigned union_degree(longint unsigned x);
        int unsigned a, b;
        a = degree_at(0, clamp_pts(cnt_a), x);
        b = degree_at(1, clamp_pts(cnt_b), x);
        if (mode != 0) return a > b ? a : b;
        return a < b ? a : b;
    endfunction

    function automatic t_centroid centroid_of_run();
        int unsigned n, d, prev, s;
        longint unsigned area, moment, xp, xn, c;
        t_centroid r;
        n = samples < 2 ? 2 : (samples > MaxSamples ? MaxSamples : samples);
        area = 0;
        moment = 0;
        xp = start_pos;
        prev = union_degree(xp);
        for (int k = 1; k < n; k++) begin
            xn = longint'(start_pos) + longint'(k) * step;
            d = union_degree(xn);
            s = prev + d;
            area += s;
            moment += longint'(s) * (2 * xp + step);
            prev = d;
            xp = xn;
        end
        if (area == 0) begin
            r.centroid = '0;
            r.empty = 1'b1;
        end else begin
            c = (moment + area) / (2 * area);
            r.centroid = c > 65535 ? 16'hFFFF : c[15:0];
            r.empty = 1'b0;
        end
        return r;
    endfunction

    // driver: update the model or predict on each accepted beat, then present the next item after its gap
    always @(posedge i_clk) begin
        t_fuzzy_req it;
        bit fire;
        if (!i_rst_n) begin
            in_if.valid <= 0;
        end else begin
            fire = in_if.valid && in_if.ready;
            if (fire) begin
                if (in_if.req_type == ReqLoad) begin
                    bp_pos[in_if.set_select*MaxPoints + in_if.point_index] = in_if.point_position;
                    bp_deg[in_if.set_select*MaxPoints + in_if.point_index] = in_if.point_degree;
                    loads++;
                end else begin
                    centroid_q.push_back(centroid_of_run());
                    runs++;
                end
            end
            if (!in_if.valid || fire) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_if.valid <= 0;
                end else if (pending_q.size() > 0) begin
                    it = pending_q.pop_front();
                    in_if.valid <= 1;
                    in_if.req_type <= it.req;
                    in_if.set_select <= it.sel;
                    in_if.point_index <= it.idx;
                    in_if.point_position <= it.pos;
                    in_if.point_degree <= it.deg;
                    in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                end else begin
                    in_if.valid <= 0;
                end
            end
        end
    end

    // monitor: check each accepted beat, stall the ready line at random
    always @(posedge i_clk) begin
        t_centroid want;
        int st;
        if (!i_rst_n) begin
            out_if.ready <= 0;
        end else if (out_if.valid && out_if.ready) begin
            if (centroid_q.size() == 0) begin
                report("unexpected beat centroid", out_if.centroid, 0);
            end else begin
                want = centroid_q.pop_front();
                checked++;
                if (out_if.centroid !== want.centroid)
                    report("centroid", out_if.centroid, want.centroid);
                if (out_if.empty_area !== want.empty)
                    report("empty_area", out_if.empty_area, want.empty);
            end
            st = $urandom_range(0, 4);
            out_stall <= st;
            out_if.ready <= (st == 0);
        end else if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_if.ready <= (out_stall == 1);
        end else begin
            out_if.ready <= 1;
        end
    end

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v[15:0];
        case (idx)
            CFG_START: start_pos = v & 16'hFFFF;
            CFG_STEP:  step = v & 16'hFFFF;
            CFG_COUNT: samples = v & 11'h7FF;
            CFG_CNT_A: cnt_a = v & 4'hF;
            CFG_CNT_B: cnt_b = v & 4'hF;
            CFG_MODE:  mode = v & 1;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic push_load(bit sel, int idx, int unsigned pos, int unsigned deg);
        t_fuzzy_req it;
        it.req = ReqLoad;
        it.sel = sel;
        it.idx = IdxW'(idx);
        it.pos = PosW'(pos);
        it.deg = DegW'(deg);
        pending_q.push_back(it);
    endtask

    task automatic push_run();
        t_fuzzy_req it;
        it.req = ReqRun;
        it.sel = 1'($urandom_range(0, 1));
        it.idx = IdxW'($urandom_range(0, 7));
        it.pos = PosW'($urandom);
        it.deg = DegW'($urandom);
        pending_q.push_back(it);
    endtask

    task automatic push_set(bit sel);
        int unsigned p[$];
        for (int i = 0; i < MaxPoints; i++) p.push_back($urandom_range(0, 65535));
        p.sort();
        for (int i = 0; i < MaxPoints; i++)
            push_load(sel, i, p[i], ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511)
                                                              : $urandom_range(0, 256));
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_if.valid || centroid_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_phase(int nitems);
        int k;
        k = 0;
        while (k < nitems) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    push_set($urandom_range(0, 1));
                    push_run();
                    k += 9;
                end
                4, 5: begin
                    push_load($urandom_range(0, 1), $urandom_range(0, 7), $urandom,
                              $urandom_range(0, 511));
                    k++;
                end
                default: begin
                    push_run();
                    k++;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_START;
        i_cfg_data = 0;
        in_if.valid = 0;
        in_if.req_type = ReqLoad;
        in_if.set_select = SetA;
        in_if.point_index = 0;
        in_if.point_position = 0;
        in_if.point_degree = 0;
        out_if.ready = 0;
        foreach (bp_pos[i]) begin
            bp_pos[i] = 0;
            bp_deg[i] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // fill every slot first so no run touches an unwritten breakpoint
        push_load(SetA, 0, 0, 0);
        push_load(SetA, 1, 400, 256);
        push_load(SetA, 2, 900, 511);
        push_load(SetA, 3, 1200, 100);
        push_load(SetA, 4, 3000, 300);
        push_load(SetA, 5, 8000, 0);
        push_load(SetA, 6, 30000, 200);
        push_load(SetA, 7, 65535, 256);
        push_load(SetB, 0, 200, 0);
        push_load(SetB, 1, 700, 0);
        push_load(SetB, 2, 700, 256);
        push_load(SetB, 3, 1500, 128);
        push_load(SetB, 4, 1400, 500);
        push_load(SetB, 5, 20000, 64);
        push_load(SetB, 6, 40000, 255);
        push_load(SetB, 7, 65535, 1);
        push_run();
        drain();

        // low extremes: single breakpoints, min, two samples; B is flat zero so area is zero
        cfg_write(CFG_START, 0);
        cfg_write(CFG_STEP, 1);
        cfg_write(CFG_COUNT, 0);
        cfg_write(CFG_CNT_A, 0);
        cfg_write(CFG_CNT_B, 1);
        cfg_write(CFG_MODE, 0);
        cfg_write(CfgUnused, 16'hFFFF);
        push_run();
        drain();
        cfg_write(CFG_COUNT, 2);
        push_run();
        drain();

        // high extremes: saturated counts, largest step, centroid saturates
        cfg_write(CFG_START, 65535);
        cfg_write(CFG_STEP, 65535);
        cfg_write(CFG_COUNT, 2047);
        cfg_write(CFG_CNT_A, 15);
        cfg_write(CFG_CNT_B, 8);
        cfg_write(CFG_MODE, 1);
        push_run();
        drain();

        // zero step, unsorted sets handled through the full slot range
        cfg_write(CFG_START, 750);
        cfg_write(CFG_STEP, 0);
        cfg_write(CFG_COUNT, 5);
        push_run();
        drain();
        cfg_write(CFG_COUNT, 1024);
        cfg_write(CFG_STEP, 64);
        cfg_write(CFG_START, 0);
        push_run();
        drain();

        for (int p = 0; p < 5; p++) begin
            cfg_write(CFG_START, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000)
                                                            : $urandom_range(0, 65535));
            cfg_write(CFG_STEP, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                           : $urandom_range(1, 600));
            cfg_write(CFG_COUNT, $urandom_range(2, 48));
            cfg_write(CFG_CNT_A, $urandom_range(0, 15));
            cfg_write(CFG_CNT_B, $urandom_range(0, 15));
            cfg_write(CFG_MODE, p % 2);
            random_phase(22);
        end

        $display("covered %0d breakpoint loads and %0d runs, %0d centroid beats checked",
                 loads, runs, checked);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/fucd_pkg.sv
design/fucd_in_if.sv
design/fucd_out_if.sv
design/fucd_div.sv
design/fucd_store.sv
design/fuzzy_union_centroid_defuzzifier.sv
tb/fuzzy_union_centroid_defuzzifier_tb.sv
